### design/igscs_pkg.sv
// types, codes and crc helpers shared by the gas sensor command slave
`default_nettype none

package igscs_pkg;

    // bus event codes carried in the mode field
    localparam logic [2:0] MODE_WR_START = 3'd0;
    localparam logic [2:0] MODE_RD_START = 3'd1;
    localparam logic [2:0] MODE_WR_BYTE  = 3'd2;
    localparam logic [2:0] MODE_RD_BYTE  = 3'd3;
    localparam logic [2:0] MODE_STOP     = 3'd4;
    localparam logic [2:0] MODE_SAMPLE   = 3'd5;

    // sensor command words
    localparam logic [15:0] CMD_START_PERIODIC = 16'h21b1;
    localparam logic [15:0] CMD_START_LOWPOWER = 16'h21ac;
    localparam logic [15:0] CMD_READ_MEAS      = 16'hec05;
    localparam logic [15:0] CMD_STOP_PERIODIC  = 16'h3f86;
    localparam logic [15:0] CMD_GET_SERIAL     = 16'h3682;
    localparam logic [15:0] CMD_DATA_READY     = 16'he4b8;
    localparam logic [15:0] CMD_SET_TOFFSET    = 16'h241d;
    localparam logic [15:0] CMD_GET_TOFFSET    = 16'h2318;
    localparam logic [15:0] CMD_SET_ALTITUDE   = 16'h2427;
    localparam logic [15:0] CMD_GET_ALTITUDE   = 16'h2322;
    localparam logic [15:0] CMD_SET_AUTOCAL    = 16'h2416;
    localparam logic [15:0] CMD_GET_AUTOCAL    = 16'h2313;
    localparam logic [15:0] CMD_SELF_TEST      = 16'h3639;
    localparam logic [15:0] CMD_FACTORY_RESET  = 16'h3632;
    localparam logic [15:0] CMD_SINGLE_SHOT    = 16'h219d;
    localparam logic [15:0] CMD_SINGLE_RHT     = 16'h2196;

    // configuration register indexes
    localparam logic [1:0] REG_SERIAL_HIGH = 2'd0;
    localparam logic [1:0] REG_SERIAL_MID  = 2'd1;
    localparam logic [1:0] REG_SERIAL_LOW  = 2'd2;

    localparam logic [15:0] SERIAL_HIGH_RST = 16'd48642;
    localparam logic [15:0] SERIAL_MID_RST  = 16'd32519;
    localparam logic [15:0] SERIAL_LOW_RST  = 16'd15355;

    // factory measurement words
    localparam logic [15:0] MEAS_CO2_RST  = 16'd420;
    localparam logic [15:0] MEAS_TEMP_RST = 16'd26214;
    localparam logic [15:0] MEAS_HUM_RST  = 16'd32768;

    // response lengths in bytes
    localparam logic [3:0] RESP_LEN_NONE   = 4'd0;
    localparam logic [3:0] RESP_LEN_SINGLE = 4'd3;
    localparam logic [3:0] RESP_LEN_TRIPLE = 4'd9;

    // byte position within a word
    localparam logic [1:0] PART_HIGH = 2'd0;
    localparam logic [1:0] PART_LOW  = 2'd1;
    localparam logic [1:0] PART_CRC  = 2'd2;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  wr_byte;
        logic [15:0] co2_word;
        logic [15:0] temp_word;
        logic [15:0] hum_word;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] rd_byte;
        logic       response_done;
        logic       crc_error;
        logic       data_ready;
    } out_beat_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] crc8_word(input logic [15:0] w);
        return crc8_byte(crc8_byte(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

endpackage

`default_nettype wire

### design/i2c_gas_sensor_command_slave_top.sv
// top level of the gas sensor command slave: a result beat out for each bus event in
//
// channel  direction  handshake              payload
// s_       in         s_valid / s_ready      s_data   (in_beat_t, one bus event)
// m_       out        m_valid / m_ready      m_data   (out_beat_t, one result)
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data (serial words)
//
// an event is caught in the input register, evaluated combinationally against the
// sensor state and written to the output register once that register is free or
// its result is being taken
// a new beat is taken every cycle while m_ready stays high; one evaluation stage sets the rate
// while a result waits on m_ready the input register takes one more beat, then s_ready drops
// aresetn is synchronous, active low; cfg_ready is always high
`default_nettype none

module i2c_gas_sensor_command_slave_top
    import igscs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,

    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_data,

    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // handshake state
    logic      in_valid_reg;
    in_beat_t  in_beat_reg;
    logic      m_valid_reg;
    out_beat_t m_data_reg;
    logic      advance;

    // configuration
    logic [15:0] serial_high_reg, serial_mid_reg, serial_low_reg;

    // sensor state
    logic [3:0][7:0]  cmd_bytes_reg,    cmd_bytes_next;   // byte 4 is never kept
    logic [2:0]       cmd_count_reg,    cmd_count_next;
    logic [15:0]      last_command_reg, last_command_next;
    logic             periodic_on_reg,  periodic_on_next;
    logic             auto_calib_reg,   auto_calib_next;
    logic [15:0]      temp_offset_reg,  temp_offset_next;
    logic [15:0]      altitude_reg,     altitude_next;
    logic [2:0][15:0] meas_words_reg,   meas_words_next;
    logic             sample_pend_reg,  sample_pend_next;
    logic [2:0][15:0] resp_words_reg,   resp_words_next;
    logic [3:0]       resp_len_reg,     resp_len_next;
    logic [3:0]       resp_idx_reg,     resp_idx_next;
    logic             resp_latched_reg, resp_latched_next;
    out_beat_t        out_next;

    // command assembly
    logic [2:0]  cnt_inc;
    logic [15:0] cmd_word;
    logic [15:0] cmd_data;
    logic        crc_ok;

    // response latch, either the held one or a fresh one on the first read
    logic [2:0][15:0] fresh_words;
    logic [3:0]       fresh_len;
    logic [2:0][15:0] eff_words;
    logic [3:0]       eff_len;
    logic [3:0]       eff_idx;
    logic [3:0]       idx_inc;
    logic [15:0]      sel_word;
    logic [1:0]       sel_part;
    logic [7:0]       sel_crc;

    // handshakes: the evaluation stage moves when the output register is free
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    // bytes 0 and 1 form the command, byte 1 may be arriving right now
    assign cnt_inc  = cmd_count_reg + 3'd1;
    assign cmd_word = {cmd_bytes_reg[0],
                       (cmd_count_reg == 3'd1) ? in_beat_reg.wr_byte : cmd_bytes_reg[1]};
    assign cmd_data = {cmd_bytes_reg[2], cmd_bytes_reg[3]};
    assign crc_ok   = (in_beat_reg.wr_byte == crc8_word(cmd_data));

    // response chosen by the last command
    always_comb begin
        fresh_words = '0;
        fresh_len   = RESP_LEN_SINGLE;
        case (last_command_reg)
            CMD_READ_MEAS: begin
                fresh_words = meas_words_reg;
                fresh_len   = RESP_LEN_TRIPLE;
            end
            CMD_GET_SERIAL: begin
                fresh_words[0] = serial_high_reg;
                fresh_words[1] = serial_mid_reg;
                fresh_words[2] = serial_low_reg;
                fresh_len      = RESP_LEN_TRIPLE;
            end
            CMD_DATA_READY:   fresh_words[0] = {15'd0, periodic_on_reg};
            CMD_GET_TOFFSET:  fresh_words[0] = temp_offset_reg;
            CMD_GET_ALTITUDE: fresh_words[0] = altitude_reg;
            CMD_GET_AUTOCAL:  fresh_words[0] = {15'd0, auto_calib_reg};
            CMD_SELF_TEST:    fresh_words[0] = '0;
            default:          fresh_len = RESP_LEN_NONE;
        endcase
    end

    assign eff_words = resp_latched_reg ? resp_words_reg : fresh_words;
    assign eff_len   = resp_latched_reg ? resp_len_reg   : fresh_len;
    assign eff_idx   = resp_latched_reg ? resp_idx_reg   : 4'd0;
    assign idx_inc   = eff_idx + 4'd1;

    // byte position to word and part
    always_comb begin
        case (eff_idx)
            4'd0: begin sel_word = eff_words[0]; sel_part = PART_HIGH; end
            4'd1: begin sel_word = eff_words[0]; sel_part = PART_LOW;  end
            4'd2: begin sel_word = eff_words[0]; sel_part = PART_CRC;  end
            4'd3: begin sel_word = eff_words[1]; sel_part = PART_HIGH; end
            4'd4: begin sel_word = eff_words[1]; sel_part = PART_LOW;  end
            4'd5: begin sel_word = eff_words[1]; sel_part = PART_CRC;  end
            4'd6: begin sel_word = eff_words[2]; sel_part = PART_HIGH; end
            4'd7: begin sel_word = eff_words[2]; sel_part = PART_LOW;  end
            4'd8: begin sel_word = eff_words[2]; sel_part = PART_CRC;  end
            default: begin sel_word = eff_words[0]; sel_part = PART_HIGH; end
        endcase
    end

    assign sel_crc = crc8_word(sel_word);

    // one bus event against the sensor state
    always_comb begin
        cmd_bytes_next    = cmd_bytes_reg;
        cmd_count_next    = cmd_count_reg;
        last_command_next = last_command_reg;
        periodic_on_next  = periodic_on_reg;
        auto_calib_next   = auto_calib_reg;
        temp_offset_next  = temp_offset_reg;
        altitude_next     = altitude_reg;
        meas_words_next   = meas_words_reg;
        sample_pend_next  = sample_pend_reg;
        resp_words_next   = resp_words_reg;
        resp_len_next     = resp_len_reg;
        resp_idx_next     = resp_idx_reg;
        resp_latched_next = resp_latched_reg;
        out_next          = '0;

        case (in_beat_reg.mode)
            MODE_WR_START: cmd_count_next = '0;

            MODE_WR_BYTE: begin
                // count never rests at five; the fifth byte is checked as crc, not stored
                if (cmd_count_reg < 3'd4) begin
                    cmd_bytes_next[cmd_count_reg[1:0]] = in_beat_reg.wr_byte;
                end
                cmd_count_next = cnt_inc;
                if (cnt_inc >= 3'd2) begin
                    last_command_next = cmd_word;
                end
                if (cnt_inc == 3'd2) begin
                    case (cmd_word)
                        CMD_STOP_PERIODIC: periodic_on_next = 1'b0;
                        CMD_START_PERIODIC, CMD_START_LOWPOWER: begin
                            periodic_on_next = 1'b1;
                            sample_pend_next = 1'b1;
                        end
                        CMD_SINGLE_SHOT, CMD_SINGLE_RHT: sample_pend_next = 1'b1;
                        CMD_FACTORY_RESET: begin
                            temp_offset_next = '0;
                            altitude_next    = '0;
                            auto_calib_next  = 1'b1;
                            meas_words_next  = {MEAS_HUM_RST, MEAS_TEMP_RST, MEAS_CO2_RST};
                        end
                        default: ;
                    endcase
                end
                if (cnt_inc == 3'd5) begin
                    // data word with crc byte
                    if (crc_ok) begin
                        case (cmd_word)
                            CMD_SET_TOFFSET:  temp_offset_next = cmd_data;
                            CMD_SET_ALTITUDE: altitude_next    = cmd_data;
                            CMD_SET_AUTOCAL:  auto_calib_next  = (cmd_data == 16'd1);
                            default: ;
                        endcase
                    end else begin
                        out_next.crc_error = 1'b1;
                    end
                    cmd_count_next = '0;
                end
            end

            MODE_RD_BYTE: begin
                resp_words_next   = eff_words;
                resp_len_next     = eff_len;
                resp_idx_next     = eff_idx;
                resp_latched_next = 1'b1;
                if (eff_idx < eff_len) begin
                    case (sel_part)
                        PART_HIGH: out_next.rd_byte = sel_word[15:8];
                        PART_LOW:  out_next.rd_byte = sel_word[7:0];
                        default:   out_next.rd_byte = sel_crc;
                    endcase
                    resp_idx_next = idx_inc;
                end
                // end of response, or nothing to send at all
                if (resp_idx_next >= eff_len) begin
                    resp_latched_next      = 1'b0;
                    cmd_count_next         = '0;
                    out_next.response_done = 1'b1;
                end
            end

            MODE_SAMPLE: begin
                if (periodic_on_reg || sample_pend_reg) begin
                    meas_words_next = {in_beat_reg.hum_word, in_beat_reg.temp_word,
                                       in_beat_reg.co2_word};
                    sample_pend_next = 1'b0;
                end
            end

            default: ;  // read start, stop and unused codes leave the state alone
        endcase

        out_next.data_ready = periodic_on_next;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            in_beat_reg <= s_data;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance) begin
            m_data_reg <= out_next;
        end
    end

    // serial number registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            serial_high_reg <= SERIAL_HIGH_RST;
            serial_mid_reg  <= SERIAL_MID_RST;
            serial_low_reg  <= SERIAL_LOW_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SERIAL_HIGH: serial_high_reg <= cfg_data;
                REG_SERIAL_MID:  serial_mid_reg  <= cfg_data;
                REG_SERIAL_LOW:  serial_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // sensor state moves with each evaluated beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_count_reg    <= '0;
            last_command_reg <= '0;
            periodic_on_reg  <= 1'b0;
            auto_calib_reg   <= 1'b1;
            temp_offset_reg  <= '0;
            altitude_reg     <= '0;
            meas_words_reg   <= {MEAS_HUM_RST, MEAS_TEMP_RST, MEAS_CO2_RST};
            sample_pend_reg  <= 1'b0;
            resp_words_reg   <= '0;
            resp_len_reg     <= '0;
            resp_idx_reg     <= '0;
            resp_latched_reg <= 1'b0;
        end else if (advance) begin
            cmd_count_reg    <= cmd_count_next;
            last_command_reg <= last_command_next;
            periodic_on_reg  <= periodic_on_next;
            auto_calib_reg   <= auto_calib_next;
            temp_offset_reg  <= temp_offset_next;
            altitude_reg     <= altitude_next;
            meas_words_reg   <= meas_words_next;
            sample_pend_reg  <= sample_pend_next;
            resp_words_reg   <= resp_words_next;
            resp_len_reg     <= resp_len_next;
            resp_idx_reg     <= resp_idx_next;
            resp_latched_reg <= resp_latched_next;
        end
    end

    // command bytes need no reset, each is written before it is read
    always_ff @(posedge aclk) begin
        if (advance) begin
            cmd_bytes_reg <= cmd_bytes_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a held response always has bytes left to send
    a_latch_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        resp_latched_reg |-> (resp_idx_reg < resp_len_reg))
        else $error("latched response with no bytes left");

    // a finished response releases the latch and the command count
    a_done_releases: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && out_next.response_done) |=> (!resp_latched_reg && cmd_count_reg == 3'd0))
        else $error("response end did not clear latch and count");

    // a crc failure only comes at the end of a five byte command
    a_crc_err_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && out_next.crc_error) |=> (cmd_count_reg == 3'd0))
        else $error("crc error without command count reset");

    // data ready in the result follows the periodic state it leaves behind
    a_ready_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_data_reg.data_ready == periodic_on_reg))
        else $error("data_ready disagrees with periodic state");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_i2c_gas_sensor_command_slave_top.sv
// self-checking testbench for the gas sensor command slave: directed table, random bus traffic
`timescale 1ns / 1ps

module tb_i2c_gas_sensor_command_slave_top;
    import igscs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PIPE_LATENCY = 2;
    localparam int PHASE_EVENTS = 370;

    // mode codes the block treats like a stop
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef struct {
        in_beat_t  ev;
        bit        typed;
        out_beat_t want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_beat_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_beat_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_SERIAL_HIGH;
    logic [15:0] cfg_data  = '0;

    // typed expectation travelling with the beat on the input channel
    bit        row_typed = 1'b0;
    out_beat_t row_want  = '0;

    bit tx_idle_on  = 1'b0;
    bit rx_stall_on = 1'b0;

    int unsigned events_sent = 0;
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    out_beat_t expected_replies[$];
    dir_row_t  directed_rows[$];

    // sensor state as seen from the bus
    logic [7:0]  cmd_buf [5];
    int unsigned cmd_fill;
    logic [15:0] recent_cmd;
    bit          periodic_mode;
    bit          auto_cal;
    bit          sample_req;
    logic [15:0] t_offset;
    logic [15:0] alt_word;
    logic [15:0] meas [3];
    logic [15:0] resp_word [3];
    logic [3:0]  resp_bytes;
    int unsigned resp_pos;
    bit          resp_held;
    logic [15:0] serial_reg [3];

    i2c_gas_sensor_command_slave_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    // crc-8, msb first, one bit per step
    function automatic logic [7:0] crc8_of_word(input logic [15:0] w);
        logic [7:0] c;
        c = CRC_INIT;
        for (int i = 15; i >= 0; i--) begin
            c = (c[7] ^ w[i]) ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic void factory_meas();
        meas[0] = MEAS_CO2_RST;
        meas[1] = MEAS_TEMP_RST;
        meas[2] = MEAS_HUM_RST;
    endfunction

    function automatic void sensor_reset();
        cmd_fill      = 0;
        recent_cmd    = '0;
        periodic_mode = 1'b0;
        auto_cal      = 1'b1;
        sample_req    = 1'b0;
        t_offset      = '0;
        alt_word      = '0;
        factory_meas();
        resp_word[0]  = '0;
        resp_word[1]  = '0;
        resp_word[2]  = '0;
        resp_bytes    = RESP_LEN_NONE;
        resp_pos      = 0;
        resp_held     = 1'b0;
        serial_reg[REG_SERIAL_HIGH] = SERIAL_HIGH_RST;
        serial_reg[REG_SERIAL_MID]  = SERIAL_MID_RST;
        serial_reg[REG_SERIAL_LOW]  = SERIAL_LOW_RST;
    endfunction

    // returns the crc error flag of this byte
    function automatic bit take_cmd_byte(input logic [7:0] b);
        logic [15:0] cmd;
        logic [15:0] data;
        bit          err;
        err = 1'b0;
        if (cmd_fill < 5) begin
            cmd_buf[cmd_fill] = b;
            cmd_fill++;
        end
        if (cmd_fill < 2) return 1'b0;
        cmd        = {cmd_buf[0], cmd_buf[1]};
        recent_cmd = cmd;
        if (cmd_fill == 2) begin
            case (cmd)
                CMD_STOP_PERIODIC: periodic_mode = 1'b0;
                CMD_START_PERIODIC, CMD_START_LOWPOWER: begin
                    periodic_mode = 1'b1;
                    sample_req    = 1'b1;
                end
                CMD_SINGLE_SHOT, CMD_SINGLE_RHT: sample_req = 1'b1;
                CMD_FACTORY_RESET: begin
                    t_offset = '0;
                    alt_word = '0;
                    auto_cal = 1'b1;
                    factory_meas();
                end
                default: ;
            endcase
        end else if (cmd_fill >= 5) begin
            data = {cmd_buf[2], cmd_buf[3]};
            if (cmd_buf[4] == crc8_of_word(data)) begin
                if (cmd == CMD_SET_TOFFSET) t_offset = data;
                else if (cmd == CMD_SET_ALTITUDE) alt_word = data;
                else if (cmd == CMD_SET_AUTOCAL) auto_cal = (data == 16'd1);
            end else begin
                err = 1'b1;
            end
            cmd_fill = 0;
        end
        return err;
    endfunction

    function automatic void latch_reply();
        resp_pos     = 0;
        resp_held    = 1'b1;
        resp_word[0] = '0;
        resp_word[1] = '0;
        resp_word[2] = '0;
        resp_bytes   = RESP_LEN_SINGLE;
        case (recent_cmd)
            CMD_READ_MEAS: begin
                resp_word[0] = meas[0];
                resp_word[1] = meas[1];
                resp_word[2] = meas[2];
                resp_bytes   = RESP_LEN_TRIPLE;
            end
            CMD_GET_SERIAL: begin
                resp_word[0] = serial_reg[REG_SERIAL_HIGH];
                resp_word[1] = serial_reg[REG_SERIAL_MID];
                resp_word[2] = serial_reg[REG_SERIAL_LOW];
                resp_bytes   = RESP_LEN_TRIPLE;
            end
            CMD_DATA_READY:   resp_word[0] = {15'd0, periodic_mode};
            CMD_GET_TOFFSET:  resp_word[0] = t_offset;
            CMD_GET_ALTITUDE: resp_word[0] = alt_word;
            CMD_GET_AUTOCAL:  resp_word[0] = {15'd0, auto_cal};
            CMD_SELF_TEST:    ;
            default:          resp_bytes = RESP_LEN_NONE;
        endcase
    endfunction

    // {done, byte} for one read byte
    function automatic logic [8:0] next_reply_byte();
        logic [7:0]  b;
        logic [15:0] w;
        bit          done;
        b = '0;
        if (!resp_held) latch_reply();
        if (resp_pos < resp_bytes && resp_pos < 9) begin
            w = resp_word[(resp_pos / 3) % 3];
            case (2'(resp_pos % 3))
                PART_HIGH: b = w[15:8];
                PART_LOW:  b = w[7:0];
                default:   b = crc8_of_word(w);
            endcase
            resp_pos++;
        end
        done = (resp_pos >= resp_bytes);
        if (done) begin
            resp_held = 1'b0;
            cmd_fill  = 0;
        end
        return {done, b};
    endfunction

    function automatic out_beat_t predict_sensor_reply(input in_beat_t ev);
        out_beat_t r;
        r = '0;
        case (ev.mode)
            MODE_WR_START: cmd_fill = 0;
            MODE_WR_BYTE:  r.crc_error = take_cmd_byte(ev.wr_byte);
            MODE_RD_BYTE:  {r.response_done, r.rd_byte} = next_reply_byte();
            MODE_SAMPLE: begin
                // a sample nobody asked for is dropped
                if (periodic_mode || sample_req) begin
                    meas[0]    = ev.co2_word;
                    meas[1]    = ev.temp_word;
                    meas[2]    = ev.hum_word;
                    sample_req = 1'b0;
                end
            end
            default: ;
        endcase
        r.data_ready = periodic_mode;
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        end
    endtask

    task automatic check_reply(input out_beat_t got);
        out_beat_t want;
        if (expected_replies.size() == 0) begin
            fail_count++;
            $error("result beat with nothing expected: %h", got);
        end else begin
            want = expected_replies.pop_front();
            check_field("rd_byte", want.rd_byte, got.rd_byte);
            check_field("response_done", 8'(want.response_done), 8'(got.response_done));
            check_field("crc_error", 8'(want.crc_error), 8'(got.crc_error));
            check_field("data_ready", 8'(want.data_ready), 8'(got.data_ready));
        end
    endtask

    // results are checked before the new beat is predicted; latency keeps them apart
    always @(posedge aclk) begin : scoreboard
        out_beat_t predicted;
        if (aresetn) begin
            if (m_valid && m_ready) check_reply(m_data);
            if (s_valid && s_ready) begin
                predicted = predict_sensor_reply(s_data);
                expected_replies.push_back(row_typed ? row_want : predicted);
            end
        end
    end

    // result side back-pressure
    always begin
        @(negedge aclk);
        if (rx_stall_on && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        m_ready <= 1'b1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic out_beat_t reply(input logic [7:0] rd, input bit done, input bit err,
                                        input bit dr);
        out_beat_t r;
        r.rd_byte       = rd;
        r.response_done = done;
        r.crc_error     = err;
        r.data_ready    = dr;
        return r;
    endfunction

    function automatic dir_row_t bus_row(input logic [2:0] m, input logic [7:0] b,
                                         input bit typed, input out_beat_t want);
        dir_row_t r;
        r.ev         = '0;
        r.ev.mode    = m;
        r.ev.wr_byte = b;
        r.typed      = typed;
        r.want       = want;
        return r;
    endfunction

    function automatic dir_row_t word_row(input logic [2:0] m, input logic [15:0] c,
                                          input logic [15:0] t, input logic [15:0] h,
                                          input out_beat_t want);
        dir_row_t r;
        r.ev.mode      = m;
        r.ev.wr_byte   = 8'hFF;
        r.ev.co2_word  = c;
        r.ev.temp_word = t;
        r.ev.hum_word  = h;
        r.typed        = 1'b1;
        r.want         = want;
        return r;
    endfunction

    task automatic load_directed();
        // nothing latched and no command: empty response
        directed_rows.push_back(bus_row(MODE_RD_BYTE, 8'h00, 1, reply(8'h00, 1, 0, 0)));
        directed_rows.push_back(word_row(MODE_SPARE_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                         reply(8'h00, 0, 0, 0)));
        // start periodic, then a sample at the field extremes is stored
        directed_rows.push_back(bus_row(MODE_WR_START, 8'h00, 1, reply(8'h00, 0, 0, 0)));
        directed_rows.push_back(bus_row(MODE_WR_BYTE, CMD_START_PERIODIC[15:8], 1,
                                        reply(8'h00, 0, 0, 0)));
        directed_rows.push_back(bus_row(MODE_WR_BYTE, CMD_START_PERIODIC[7:0], 1,
                                        reply(8'h00, 0, 0, 1)));
        directed_rows.push_back(word_row(MODE_SAMPLE, 16'hFFFF, 16'h0000, 16'hFFFF,
                                         reply(8'h00, 0, 0, 1)));
        // read the whole measurement back, last byte closes the response
        directed_rows.push_back(bus_row(MODE_WR_START, 8'h00, 1, reply(8'h00, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_WR_BYTE, CMD_READ_MEAS[15:8], 1,
                                        reply(8'h00, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_WR_BYTE, CMD_READ_MEAS[7:0], 1,
                                        reply(8'h00, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_RD_START, 8'hFF, 1, reply(8'h00, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_RD_BYTE, 8'h00, 1, reply(8'hFF, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_RD_BYTE, 8'h00, 1, reply(8'hFF, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_RD_BYTE, 8'h00, 0, '0));
        directed_rows.push_back(bus_row(MODE_RD_BYTE, 8'h00, 1, reply(8'h00, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_RD_BYTE, 8'h00, 1, reply(8'h00, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_RD_BYTE, 8'h00, 0, '0));
        directed_rows.push_back(bus_row(MODE_RD_BYTE, 8'h00, 1, reply(8'hFF, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_RD_BYTE, 8'h00, 1, reply(8'hFF, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_RD_BYTE, 8'h00, 0, '0));
        // set temperature offset with a corrupt crc byte
        directed_rows.push_back(bus_row(MODE_WR_START, 8'h00, 1, reply(8'h00, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_WR_BYTE, CMD_SET_TOFFSET[15:8], 1,
                                        reply(8'h00, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_WR_BYTE, CMD_SET_TOFFSET[7:0], 1,
                                        reply(8'h00, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_WR_BYTE, 8'h00, 1, reply(8'h00, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_WR_BYTE, 8'h00, 1, reply(8'h00, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_WR_BYTE, 8'h00, 1, reply(8'h00, 0, 1, 1)));
        directed_rows.push_back(bus_row(MODE_STOP, 8'hFF, 1, reply(8'h00, 0, 0, 1)));
        // stop periodic without a write start, then an unrequested sample is dropped
        directed_rows.push_back(bus_row(MODE_WR_BYTE, CMD_STOP_PERIODIC[15:8], 1,
                                        reply(8'h00, 0, 0, 1)));
        directed_rows.push_back(bus_row(MODE_WR_BYTE, CMD_STOP_PERIODIC[7:0], 1,
                                        reply(8'h00, 0, 0, 0)));
        directed_rows.push_back(word_row(MODE_SAMPLE, 16'h1234, 16'h5678, 16'h9ABC,
                                         reply(8'h00, 0, 0, 0)));
    endtask

    // called and returns at a falling edge; valid stays up for a following beat
    task automatic drive_event(input in_beat_t ev, input bit typed, input out_beat_t want);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_data    <= ev;
        row_typed <= typed;
        row_want  <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        events_sent++;
        @(negedge aclk);
    endtask

    task automatic put(input logic [2:0] m, input logic [7:0] b);
        in_beat_t ev;
        ev.mode      = m;
        ev.wr_byte   = b;
        ev.co2_word  = rand_word();
        ev.temp_word = rand_word();
        ev.hum_word  = rand_word();
        drive_event(ev, 1'b0, '0);
    endtask

    // hold the sender until every result is back
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_serial(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        serial_reg[idx] = val;
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_query_cmd();
        case ($urandom_range(0, 8))
            0:       return CMD_READ_MEAS;
            1:       return CMD_GET_SERIAL;
            2:       return CMD_DATA_READY;
            3:       return CMD_GET_TOFFSET;
            4:       return CMD_GET_ALTITUDE;
            5:       return CMD_GET_AUTOCAL;
            6:       return CMD_SELF_TEST;
            7:       return CMD_READ_MEAS;
            default: return rand_word();
        endcase
    endfunction

    function automatic logic [15:0] pick_action_cmd();
        case ($urandom_range(0, 6))
            0:       return CMD_START_PERIODIC;
            1:       return CMD_START_LOWPOWER;
            2:       return CMD_STOP_PERIODIC;
            3:       return CMD_SINGLE_SHOT;
            4:       return CMD_SINGLE_RHT;
            5:       return CMD_FACTORY_RESET;
            default: return rand_word();
        endcase
    endfunction

    function automatic logic [15:0] pick_set_cmd();
        case ($urandom_range(0, 3))
            0:       return CMD_SET_TOFFSET;
            1:       return CMD_SET_ALTITUDE;
            2:       return CMD_SET_AUTOCAL;
            default: return rand_word();
        endcase
    endfunction

    task automatic run_transaction(input bit calm);
        int          kind;
        int          n;
        logic [15:0] cmd;
        logic [15:0] data;
        logic [7:0]  crc;
        kind = $urandom_range(0, 99);
        if (!calm && $urandom_range(0, 24) == 0) begin
            tx_idle_on  = $urandom_range(0, 1);
            rx_stall_on <= $urandom_range(0, 1);
        end
        if (!calm && $urandom_range(0, 49) == 0) settle();
        if (kind < 30) begin
            // command then read, usually the full response length
            cmd = pick_query_cmd();
            put(MODE_WR_START, 8'($urandom));
            put(MODE_WR_BYTE, cmd[15:8]);
            put(MODE_WR_BYTE, cmd[7:0]);
            if ($urandom_range(0, 3) != 0) put(MODE_STOP, 8'($urandom));
            put(MODE_RD_START, 8'($urandom));
            if ($urandom_range(0, 1) == 0)
                n = (cmd == CMD_READ_MEAS || cmd == CMD_GET_SERIAL) ? 9 : 3;
            else
                n = $urandom_range(1, 12);
            repeat (n) put(MODE_RD_BYTE, 8'($urandom));
            put(MODE_STOP, 8'($urandom));
        end else if (kind < 45) begin
            // five byte set command, crc mostly good
            cmd  = pick_set_cmd();
            data = rand_word();
            if (cmd == CMD_SET_AUTOCAL && $urandom_range(0, 1) == 0)
                data = {15'd0, 1'($urandom)};
            crc = crc8_of_word(data);
            if ($urandom_range(0, 4) == 0) crc = crc ^ 8'(1 << $urandom_range(0, 7));
            put(MODE_WR_START, 8'($urandom));
            put(MODE_WR_BYTE, cmd[15:8]);
            put(MODE_WR_BYTE, cmd[7:0]);
            put(MODE_WR_BYTE, data[15:8]);
            put(MODE_WR_BYTE, data[7:0]);
            put(MODE_WR_BYTE, crc);
            put(MODE_STOP, 8'($urandom));
        end else if (kind < 60) begin
            cmd = pick_action_cmd();
            put(MODE_WR_START, 8'($urandom));
            put(MODE_WR_BYTE, cmd[15:8]);
            put(MODE_WR_BYTE, cmd[7:0]);
            put(MODE_STOP, 8'($urandom));
        end else if (kind < 75) begin
            repeat ($urandom_range(1, 3)) put(MODE_SAMPLE, 8'($urandom));
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 4))
                put(3'($urandom_range(MODE_WR_START, MODE_SPARE_HI)), 8'($urandom));
        end else begin
            // broken sequences: bytes without a write start, unfinished commands
            if ($urandom_range(0, 1) == 0) put(MODE_WR_START, 8'($urandom));
            repeat ($urandom_range(1, 4)) put(MODE_WR_BYTE, 8'($urandom));
            if ($urandom_range(0, 1) == 0) put(MODE_SPARE_LO, 8'($urandom));
            repeat ($urandom_range(0, 3)) put(MODE_RD_BYTE, 8'($urandom));
        end
    endtask

    // ---------------------------------------------------------------- run

    initial begin
        logic [15:0] w_high;
        logic [15:0] w_mid;
        logic [15:0] w_low;
        int unsigned target;
        sensor_reset();
        load_directed();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn     <= 1'b1;
        tx_idle_on  = 1'b1;
        rx_stall_on <= 1'b1;

        foreach (directed_rows[i])
            drive_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

        // first phase on reset serial words, then new words between phases
        for (int phase = 0; phase < 5; phase++) begin
            if (phase > 0) begin
                settle();
                case (phase)
                    1: begin w_high = 16'hFFFF; w_mid = 16'hFFFF; w_low = 16'hFFFF; end
                    2: begin w_high = 16'h0000; w_mid = 16'h0000; w_low = 16'h0000; end
                    3: begin w_high = rand_word(); w_mid = rand_word(); w_low = rand_word(); end
                    default: begin w_high = 16'h0000; w_mid = 16'($urandom); w_low = 16'hFFFF; end
                endcase
                write_serial(REG_SERIAL_HIGH, w_high);
                write_serial(REG_SERIAL_MID, w_mid);
                write_serial(REG_SERIAL_LOW, w_low);
                cfg_valid <= 1'b0;
            end
            // last phase runs flat out on both sides
            if (phase == 4) begin
                tx_idle_on  = 1'b0;
                rx_stall_on <= 1'b0;
            end
            target = events_sent + PHASE_EVENTS;
            while (events_sent < target) run_transaction(phase == 4);
        end

        s_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 4) @(posedge aclk);

        if (fail_count == 0 && expected_replies.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
